/* hdl/sha1sh_pkg.sv */
// Shared constants, types and round functions of the SHA-1 stream hasher.
package sha1sh_pkg;

    // Initial chaining values.
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // Padding byte and the block layout.
    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [5:0] LAST_POS     = 6'd63;
    localparam logic [6:0] LAST_ROUND   = 7'd79;
    localparam logic [6:0] FIRST_EXPAND = 7'd16;
    localparam logic [2:0] LAST_WORD    = 3'd4;
    localparam logic [6:0] GROUP_1      = 7'd20;
    localparam logic [6:0] GROUP_2      = 7'd40;
    localparam logic [6:0] GROUP_3      = 7'd60;

    typedef logic [31:0] word_t;

    // Control of the message schedule window.
    typedef struct packed {
        logic push_byte;   // shift one message byte in
        logic step;        // advance one round
        logic expand;      // round 16 or later: compute a new schedule word
    } sched_ctl_t;

    // Control of the round unit.
    typedef struct packed {
        logic       load;  // copy the chaining words into the working variables
        logic       step;  // perform one round
        logic [6:0] rnd;   // index of the round being performed
    } rnd_ctl_t;

    function automatic word_t rol32(input word_t x, input int unsigned n);
        word_t r;
        r = (x << n) | (x >> (32 - n));
        return r;
    endfunction

    // Boolean function of the round group.
    function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        if (rnd < GROUP_1) begin
            f = (b & c) | (~b & d);
        end else if (rnd < GROUP_2) begin
            f = b ^ c ^ d;
        end else if (rnd < GROUP_3) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    // Additive constant of the round group.
    function automatic word_t round_k(input logic [6:0] rnd);
        word_t k;
        if (rnd < GROUP_1) begin
            k = K_0;
        end else if (rnd < GROUP_2) begin
            k = K_1;
        end else if (rnd < GROUP_3) begin
            k = K_2;
        end else begin
            k = K_3;
        end
        return k;
    endfunction

endpackage

/* hdl/sha1_stream_hasher_top.sv */
// Top level of the SHA-1 stream hasher: byte intake, padding sequencer and digest output.
//
// Channel  Direction  tdata                tuser        tlast
// s_       in         [7:0] msg_byte       has_byte     end_of_message
// m_       out        [31:0] digest_word   -            last_word
//
// A transaction that does not complete a block pushes its byte, if any; a full block then
// runs the 80 rounds of the shared unit and then the chaining add.
// Closing a message with p bytes buffered pushes 64 - p pad, zero and length bytes,
// one a cycle outside compressions (128 - p when p is 56 or more), with a step without
// a push before the length; five digest words follow, one per cycle while m_tready
// is high, and s_tready stays low throughout. aresetn is synchronous, active low.
module sha1_stream_hasher_top
    import sha1sh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] msg_byte
    input  logic        s_tuser,    // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] digest_word
    output logic        m_tlast
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD80 = 3'd1;
    localparam logic [2:0] ST_PADZ  = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_COMP  = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  after_reg, after_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bits_reg, bits_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  wcnt_reg, wcnt_next;
    word_t       chain_reg  [5];
    word_t       chain_next [5];
    word_t       vars       [5];
    word_t       w_cur;

    logic        s_acc;
    logic        push;
    logic [7:0]  push_data;
    logic        wrap;
    sched_ctl_t  sched_ctl;
    rnd_ctl_t    rnd_ctl;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[0];
    assign m_tlast  = (wcnt_reg == LAST_WORD);

    // Sequencer: byte pushes, padding, compression and digest output.
    always_comb begin
        state_next = state_reg;
        after_next = after_reg;
        pos_next   = pos_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        wcnt_next  = wcnt_reg;
        chain_next = chain_reg;
        push       = 1'b0;
        push_data  = 8'h00;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    push      = s_tuser;
                    push_data = s_tdata;
                    if (s_tuser) begin
                        bits_next = bits_reg + 64'd8;
                    end
                    if (s_tuser && pos_reg == LAST_POS) begin
                        state_next = ST_COMP;
                        after_next = s_tlast ? ST_PAD80 : ST_IDLE;
                    end else if (s_tlast) begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                push       = 1'b1;
                push_data  = PAD_BYTE;
                state_next = (pos_reg == LAST_POS) ? ST_COMP : ST_PADZ;
                after_next = ST_PADZ;
            end
            ST_PADZ: begin
                if (pos_reg == LEN_POS) begin
                    state_next = ST_LEN;
                end else begin
                    push = 1'b1;
                    if (pos_reg == LAST_POS) begin
                        state_next = ST_COMP;
                        after_next = ST_PADZ;
                    end
                end
            end
            ST_LEN: begin
                // The count is shifted out most significant byte first.
                push      = 1'b1;
                push_data = bits_reg[63:56];
                bits_next = {bits_reg[55:0], 8'h00};
                if (pos_reg == LAST_POS) begin
                    state_next = ST_COMP;
                    after_next = ST_OUT;
                end
            end
            ST_COMP: begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                state_next = after_reg;
                wcnt_next  = 3'd0;
            end
            ST_OUT: begin
                // Rotate the chaining words past the output register.
                if (m_tready) begin
                    wcnt_next = wcnt_reg + 3'd1;
                    for (int i = 0; i < 4; i++) begin
                        chain_next[i] = chain_reg[i + 1];
                    end
                    chain_next[4] = chain_reg[0];
                    if (wcnt_reg == LAST_WORD) begin
                        state_next    = ST_IDLE;
                        chain_next[0] = H0_INIT;
                        chain_next[1] = H1_INIT;
                        chain_next[2] = H2_INIT;
                        chain_next[3] = H3_INIT;
                        chain_next[4] = H4_INIT;
                        pos_next      = 6'd0;
                        bits_next     = 64'd0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (push) begin
            pos_next = pos_reg + 6'd1;
        end
        if (wrap) begin
            rnd_next = 7'd0;
        end
    end

    // A push into the last byte slot completes a block.
    assign wrap = push && (pos_reg == LAST_POS);

    assign sched_ctl.push_byte = push;
    assign sched_ctl.step      = (state_reg == ST_COMP);
    assign sched_ctl.expand    = (rnd_reg >= FIRST_EXPAND);

    assign rnd_ctl.load = wrap;
    assign rnd_ctl.step = (state_reg == ST_COMP);
    assign rnd_ctl.rnd  = rnd_reg;

    // Control and chaining registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            after_reg    <= ST_IDLE;
            pos_reg      <= 6'd0;
            bits_reg     <= 64'd0;
            rnd_reg      <= 7'd0;
            wcnt_reg     <= 3'd0;
            chain_reg[0] <= H0_INIT;
            chain_reg[1] <= H1_INIT;
            chain_reg[2] <= H2_INIT;
            chain_reg[3] <= H3_INIT;
            chain_reg[4] <= H4_INIT;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
            pos_reg   <= pos_next;
            bits_reg  <= bits_next;
            rnd_reg   <= rnd_next;
            wcnt_reg  <= wcnt_next;
            chain_reg <= chain_next;
        end
    end

    sha1sh_sched u_sched (
        .aclk    (aclk),
        .ctl     (sched_ctl),
        .byte_in (push_data),
        .w_out   (w_cur)
    );

    sha1sh_round u_round (
        .aclk     (aclk),
        .ctl      (rnd_ctl),
        .w_in     (w_cur),
        .chain_in (chain_reg),
        .vars_out (vars)
    );

endmodule

/* hdl/sha1sh_sched.sv */
// Message schedule window: collects the block bytes and expands the schedule words.
module sha1sh_sched
    import sha1sh_pkg::*;
(
    input  logic       aclk,
    input  sched_ctl_t ctl,
    input  logic [7:0] byte_in,
    output word_t      w_out
);

    // Sixteen words, the oldest in the top bits; bytes enter at the bottom.
    logic [511:0] win_reg;
    logic [511:0] win_next;
    word_t        w_expanded;

    // The oldest word is used directly in the first sixteen rounds and
    // rotated back in, so that the window then holds W[t-16] to W[t-1].
    assign w_expanded = rol32(win_reg[511:480] ^ win_reg[447:416] ^
                              win_reg[255:224] ^ win_reg[95:64], 1);
    assign w_out      = ctl.expand ? w_expanded : win_reg[511:480];

    // Next window contents.
    always_comb begin
        win_next = win_reg;
        if (ctl.push_byte) begin
            win_next = {win_reg[503:0], byte_in};
        end else if (ctl.step) begin
            win_next = {win_reg[479:0], w_out};
        end
    end

    // The window needs no reset: it is always filled before it is read.
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

/* hdl/sha1sh_round.sv */
// Shared round unit: the five working variables and one SHA-1 round per cycle while step is set.
module sha1sh_round
    import sha1sh_pkg::*;
(
    input  logic     aclk,
    input  rnd_ctl_t ctl,
    input  word_t    w_in,
    input  word_t    chain_in [5],
    output word_t    vars_out [5]
);

    word_t vars_reg  [5];
    word_t vars_next [5];
    word_t tmp;

    // One round: rotate, boolean function, four additions.
    assign tmp = rol32(vars_reg[0], 5) + round_f(ctl.rnd, vars_reg[1], vars_reg[2], vars_reg[3])
               + vars_reg[4] + w_in + round_k(ctl.rnd);

    always_comb begin
        vars_next = vars_reg;
        if (ctl.load) begin
            vars_next = chain_in;
        end else if (ctl.step) begin
            vars_next[0] = tmp;
            vars_next[1] = vars_reg[0];
            vars_next[2] = rol32(vars_reg[1], 30);
            vars_next[3] = vars_reg[2];
            vars_next[4] = vars_reg[3];
        end
    end

    // Working variables are loaded before every compression.
    always_ff @(posedge aclk) begin
        vars_reg <= vars_next;
    end

    assign vars_out = vars_reg;

endmodule
